// ----- sv/lctpl_pkg.sv -----
// shared types, constants and helper functions of the lc-trie prefix lookup
package lctpl_pkg;

  localparam int unsigned NodeEntriesDef   = 4096;
  localparam int unsigned SubnetEntriesDef = 1024;
  localparam int unsigned BaseEntriesDef   = 1024;
  localparam int unsigned MaxStepsDef      = 32;
  localparam int unsigned QueueDepthDef    = 2;

  localparam int unsigned NodeW   = 22;
  localparam int unsigned SubnetW = 49;
  localparam int unsigned BaseW   = 10;

  typedef enum logic [1:0] {
    OP_WR_NODE   = 2'd0,
    OP_WR_SUBNET = 2'd1,
    OP_WR_BASE   = 2'd2,
    OP_LOOKUP    = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic        wr_ok;
    logic [11:0] index;
    logic [4:0]  branch;
    logic [4:0]  skip;
    logic [11:0] child;
    logic [31:0] addr;
    logic [5:0]  len;
    logic        has_parent;
    logic [9:0]  parent;
    logic [9:0]  base;
    logic [31:0] key;
  } item_t;

  typedef struct packed {
    logic [4:0]  branch;
    logic [4:0]  skip;
    logic [11:0] child;
  } node_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [5:0]  len;
    logic        has_parent;
    logic [9:0]  parent;
  } subnet_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NODE,
    ST_STEP,
    ST_BASE,
    ST_SUB,
    ST_DONE
  } back_state_e;

  // n key bits at msb-first position pos, bits past 31 read as zero
  function automatic logic [31:0] key_bits(input logic [31:0] key, input logic [6:0] pos,
                                           input logic [4:0] n);
    logic [31:0] t;
    logic [5:0]  sh;
    t  = key << pos[4:0];
    sh = 6'd32 - {1'b0, n};
    if (n == 5'd0 || pos >= 7'd32) begin
      return '0;
    end
    return t >> sh;
  endfunction

  // top len bits of diff all zero, length clamped to 32
  function automatic logic prefix_match(input logic [31:0] diff, input logic [5:0] len);
    logic [5:0] l;
    l = (len > 6'd32) ? 6'd32 : len;
    return (diff & ~(32'hFFFF_FFFF >> l)) == 32'd0;
  endfunction

endpackage

// ----- sv/lc_trie_prefix_lookup_top.sv -----
// top level of the lc-trie longest-prefix-match engine
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_ready_o | func_i .. lookup_key_i, one item per beat
//   out     | output    | out_valid_o/out_ready_i | found_o, match_subnet_o, one per lookup
//
// a write beat completes in the back engine when it is popped; a lookup pops, then
// reads a node and takes a step for each trie level, root included, then does the
// base read, the first subnet compare and one compare per subnet chain link, and
// hands off; front register and a 2-entry queue let new beats in while a walk runs
// reset clears the valid flags, queue pointers and walker state; table contents stay undefined until written
// a stalled result beat holds in the output register, the walker then waits
module lc_trie_prefix_lookup_top
  import lctpl_pkg::*;
#(
  parameter int unsigned NODE_ENTRIES   = NodeEntriesDef,
  parameter int unsigned SUBNET_ENTRIES = SubnetEntriesDef,
  parameter int unsigned BASE_ENTRIES   = BaseEntriesDef,
  parameter int unsigned MAX_STEPS      = MaxStepsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [11:0] entry_index_i,
  input  logic [4:0]  node_branch_i,
  input  logic [4:0]  node_skip_i,
  input  logic [11:0] node_child_i,
  input  logic [31:0] subnet_addr_i,
  input  logic [5:0]  subnet_len_i,
  input  logic        has_parent_i,
  input  logic [9:0]  parent_subnet_i,
  input  logic [9:0]  base_subnet_i,
  input  logic [31:0] lookup_key_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [9:0]  match_subnet_o
);

  // decoded item from front into queue
  logic  f_valid, f_ready;
  item_t f_item;
  // queue head into back engine
  logic  q_valid, q_pop;
  item_t q_item;

  lctpl_front #(
    .NODE_ENTRIES(NODE_ENTRIES), .SUBNET_ENTRIES(SUBNET_ENTRIES), .BASE_ENTRIES(BASE_ENTRIES)
  ) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .entry_index_i,
    .node_branch_i, .node_skip_i, .node_child_i, .subnet_addr_i, .subnet_len_i,
    .has_parent_i, .parent_subnet_i, .base_subnet_i, .lookup_key_i,
    .item_valid_o(f_valid), .item_o(f_item), .item_ready_i(f_ready)
  );

  lctpl_queue #(.DEPTH(QueueDepthDef)) u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(f_valid), .push_ready_o(f_ready), .push_item_i(f_item),
    .pop_valid_o(q_valid), .pop_item_o(q_item), .pop_i(q_pop)
  );

  lctpl_back #(
    .NODE_ENTRIES(NODE_ENTRIES), .SUBNET_ENTRIES(SUBNET_ENTRIES),
    .BASE_ENTRIES(BASE_ENTRIES), .MAX_STEPS(MAX_STEPS)
  ) u_back (
    .clk_i, .rst_ni, .pop_valid_i(q_valid), .item_i(q_item), .pop_o(q_pop),
    .out_valid_o, .out_ready_i, .found_o, .match_subnet_o
  );

endmodule

// ----- sv/lctpl_ram.sv -----
// generic single write port ram with registered read
module lctpl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/lctpl_front.sv -----
// input stage: takes beats, decodes the operation and range-checks write indexes
module lctpl_front
  import lctpl_pkg::*;
#(
  parameter int unsigned NODE_ENTRIES   = NodeEntriesDef,
  parameter int unsigned SUBNET_ENTRIES = SubnetEntriesDef,
  parameter int unsigned BASE_ENTRIES   = BaseEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [11:0] entry_index_i,
  input  logic [4:0]  node_branch_i,
  input  logic [4:0]  node_skip_i,
  input  logic [11:0] node_child_i,
  input  logic [31:0] subnet_addr_i,
  input  logic [5:0]  subnet_len_i,
  input  logic        has_parent_i,
  input  logic [9:0]  parent_subnet_i,
  input  logic [9:0]  base_subnet_i,
  input  logic [31:0] lookup_key_i,
  output logic        item_valid_o,
  output item_t       item_o,
  input  logic        item_ready_i
);

  logic        valid_q;
  item_t       item_q, item_d;
  logic [31:0] idx32;
  op_e         op;

  assign idx32      = {20'd0, entry_index_i};
  assign op         = op_e'(func_i);
  assign in_ready_o = !valid_q || item_ready_i;

  always_comb begin
    item_d            = '0;
    item_d.op         = op;
    item_d.index      = entry_index_i;
    item_d.branch     = node_branch_i;
    item_d.skip       = node_skip_i;
    item_d.child      = node_child_i;
    item_d.addr       = subnet_addr_i;
    item_d.len        = subnet_len_i;
    item_d.has_parent = has_parent_i;
    item_d.parent     = parent_subnet_i;
    item_d.base       = base_subnet_i;
    item_d.key        = lookup_key_i;
    unique case (op)
      OP_WR_NODE:   item_d.wr_ok = idx32 < 32'(NODE_ENTRIES);
      OP_WR_SUBNET: item_d.wr_ok = idx32 < 32'(SUBNET_ENTRIES);
      OP_WR_BASE:   item_d.wr_ok = idx32 < 32'(BASE_ENTRIES);
      default:      item_d.wr_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ----- sv/lctpl_queue.sv -----
// short fifo of decoded items between front and back
module lctpl_queue
  import lctpl_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepthDef,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  output item_t pop_item_o,
  input  logic  pop_i
);

  item_t         slot_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          push, pop;

  assign push_ready_o = cnt_q != CW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_item_o   = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_item_i;
    end
  end

endmodule

// ----- sv/lctpl_back.sv -----
// execution engine: table writes and the trie walk with subnet chain
module lctpl_back
  import lctpl_pkg::*;
#(
  parameter int unsigned NODE_ENTRIES   = NodeEntriesDef,
  parameter int unsigned SUBNET_ENTRIES = SubnetEntriesDef,
  parameter int unsigned BASE_ENTRIES   = BaseEntriesDef,
  parameter int unsigned MAX_STEPS      = MaxStepsDef,
  localparam int unsigned NAW = (NODE_ENTRIES > 1) ? $clog2(NODE_ENTRIES) : 1,
  localparam int unsigned SAW = (SUBNET_ENTRIES > 1) ? $clog2(SUBNET_ENTRIES) : 1,
  localparam int unsigned BAW = (BASE_ENTRIES > 1) ? $clog2(BASE_ENTRIES) : 1
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  input  item_t      item_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       found_o,
  output logic [9:0] match_subnet_o
);

  back_state_e state_q, state_d;
  logic [31:0] key_q, key_d, diff_q, diff_d;
  logic [6:0]  pos_q, pos_d, steps_q, steps_d;
  logic [4:0]  branch_q, branch_d;
  logic [11:0] idx_q, idx_d;
  logic        root_q, root_d, first_q, first_d;
  logic [9:0]  sidx_q, sidx_d, res_sub_q, res_sub_d;
  logic        res_found_q, res_found_d;
  logic        out_valid_q, out_valid_d, out_found_q, out_found_d;
  logic [9:0]  out_sub_q, out_sub_d;

  logic node_we, node_re, sub_we, sub_re, base_we, base_re;
  logic [NAW-1:0] node_raddr;
  logic [SAW-1:0] sub_raddr;
  logic [BAW-1:0] base_raddr;
  logic [NodeW-1:0]   node_rdata;
  logic [SubnetW-1:0] sub_rdata;
  logic [BaseW-1:0]   base_rdata;
  node_t   nd;
  subnet_t sn;
  logic [31:0] widx, kb, dcur;
  logic [32:0] nsum;
  logic [7:0]  psum;

  assign widx = {20'd0, item_i.index};
  assign nd   = node_t'(node_rdata);
  assign sn   = subnet_t'(sub_rdata);

  lctpl_ram #(.WIDTH(NodeW), .DEPTH(NODE_ENTRIES)) u_node_ram (
    .clk_i, .we_i(node_we), .waddr_i(widx[NAW-1:0]),
    .wdata_i({item_i.branch, item_i.skip, item_i.child}),
    .re_i(node_re), .raddr_i(node_raddr), .rdata_o(node_rdata)
  );

  lctpl_ram #(.WIDTH(SubnetW), .DEPTH(SUBNET_ENTRIES)) u_subnet_ram (
    .clk_i, .we_i(sub_we), .waddr_i(widx[SAW-1:0]),
    .wdata_i({item_i.addr, item_i.len, item_i.has_parent, item_i.parent}),
    .re_i(sub_re), .raddr_i(sub_raddr), .rdata_o(sub_rdata)
  );

  lctpl_ram #(.WIDTH(BaseW), .DEPTH(BASE_ENTRIES)) u_base_ram (
    .clk_i, .we_i(base_we), .waddr_i(widx[BAW-1:0]),
    .wdata_i(item_i.base), .re_i(base_re), .raddr_i(base_raddr), .rdata_o(base_rdata)
  );

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    diff_d      = diff_q;
    pos_d       = pos_q;
    steps_d     = steps_q;
    branch_d    = branch_q;
    idx_d       = idx_q;
    root_d      = root_q;
    first_d     = first_q;
    sidx_d      = sidx_q;
    res_found_d = res_found_q;
    res_sub_d   = res_sub_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_found_d = out_found_q;
    out_sub_d   = out_sub_q;
    pop_o       = 1'b0;
    node_we     = 1'b0;
    sub_we      = 1'b0;
    base_we     = 1'b0;
    node_re     = 1'b0;
    sub_re      = 1'b0;
    base_re     = 1'b0;
    node_raddr  = '0;
    sub_raddr   = '0;
    base_raddr  = '0;
    kb   = key_bits(key_q, pos_q, branch_q);
    nsum = {21'd0, idx_q} + {1'b0, kb};
    psum = {1'b0, pos_q} + {3'd0, branch_q} + {3'd0, nd.skip};
    dcur = first_q ? (sn.addr ^ key_q) : diff_q;

    unique case (state_q)
      ST_IDLE: begin
        pop_o = pop_valid_i;
        if (pop_valid_i) begin
          unique case (item_i.op)
            OP_WR_NODE:   node_we = item_i.wr_ok;
            OP_WR_SUBNET: sub_we  = item_i.wr_ok;
            OP_WR_BASE:   base_we = item_i.wr_ok;
            default: begin
              node_re = 1'b1;
              key_d   = item_i.key;
              root_d  = 1'b1;
              steps_d = '0;
              state_d = ST_NODE;
            end
          endcase
        end
      end
      ST_NODE: begin
        pos_d    = root_q ? {2'd0, nd.skip} : ((psum > 8'd64) ? 7'd64 : psum[6:0]);
        branch_d = nd.branch;
        idx_d    = nd.child;
        state_d  = ST_STEP;
      end
      ST_STEP: begin
        if (branch_q != 5'd0) begin
          if (steps_q >= 7'(MAX_STEPS) || nsum >= 33'(NODE_ENTRIES)) begin
            res_found_d = 1'b0;
            res_sub_d   = '0;
            state_d     = ST_DONE;
          end else begin
            steps_d    = steps_q + 1'b1;
            node_re    = 1'b1;
            node_raddr = nsum[NAW-1:0];
            root_d     = 1'b0;
            state_d    = ST_NODE;
          end
        end else if ({20'd0, idx_q} >= 32'(BASE_ENTRIES)) begin
          res_found_d = 1'b0;
          res_sub_d   = '0;
          state_d     = ST_DONE;
        end else begin
          base_re    = 1'b1;
          base_raddr = BAW'({20'd0, idx_q});
          state_d    = ST_BASE;
        end
      end
      ST_BASE: begin
        if ({22'd0, base_rdata} >= 32'(SUBNET_ENTRIES)) begin
          res_found_d = 1'b0;
          res_sub_d   = '0;
          state_d     = ST_DONE;
        end else begin
          sub_re    = 1'b1;
          sub_raddr = SAW'({22'd0, base_rdata});
          sidx_d    = base_rdata;
          first_d   = 1'b1;
          steps_d   = '0;
          state_d   = ST_SUB;
        end
      end
      ST_SUB: begin
        diff_d = dcur;
        if (prefix_match(dcur, sn.len)) begin
          res_found_d = 1'b1;
          res_sub_d   = sidx_q;
          state_d     = ST_DONE;
        end else if (steps_q >= 7'(MAX_STEPS) || !sn.has_parent
                     || {22'd0, sn.parent} >= 32'(SUBNET_ENTRIES)) begin
          res_found_d = 1'b0;
          res_sub_d   = '0;
          state_d     = ST_DONE;
        end else begin
          steps_d   = steps_q + 1'b1;
          sub_re    = 1'b1;
          sub_raddr = SAW'({22'd0, sn.parent});
          sidx_d    = sn.parent;
          first_d   = 1'b0;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_sub_d   = res_sub_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    diff_q      <= diff_d;
    pos_q       <= pos_d;
    steps_q     <= steps_d;
    branch_q    <= branch_d;
    idx_q       <= idx_d;
    root_q      <= root_d;
    first_q     <= first_d;
    sidx_q      <= sidx_d;
    res_found_q <= res_found_d;
    res_sub_q   <= res_sub_d;
    out_found_q <= out_found_d;
    out_sub_q   <= out_sub_d;
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = out_found_q;
  assign match_subnet_o = out_sub_q;

endmodule

// ----- sv/lctpl_checker.sv -----
// port-level checks for the lookup top level, bound in below
module lctpl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       found_o,
  input logic [9:0] match_subnet_o
);

  // a miss always reports subnet zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> match_subnet_o == 10'd0)
    else $error("miss beat with nonzero subnet");

  // no result beat straight out of reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result beat during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(found_o) && $stable(match_subnet_o))
    else $error("result beat changed while stalled");

endmodule

bind lc_trie_prefix_lookup_top lctpl_checker u_lctpl_checker (.*);
